FILE: hdl/aes128_block_cipher_macros.svh
// Assertion macros used by the checker file of the cipher block.
// No dependencies.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/aes_pkg.sv
// Package for the AES-128 cipher: S-box tables, GF(2^8) helpers and types.
// No dependencies.
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned KeyWordW = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned NumRoundKeys = NumRounds + 1;

  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  // control carried alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic dec;
  } stage_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01; 4'd1: v = 8'h02; 4'd2: v = 8'h04; 4'd3: v = 8'h08;
      4'd4: v = 8'h10; 4'd5: v = 8'h20; 4'd6: v = 8'h40; 4'd7: v = 8'h80;
      4'd8: v = 8'h1b; 4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_b(input block_t s, input int i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic dec);
    block_t t;
    logic [7:0] b;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          b = inv_sbox(get_b(s, ((c + 3 * r) % 4) * 4 + r));
        end else begin
          b = sbox(get_b(s, ((c + r) % 4) * 4 + r));
        end
        t[BlockW-1-8*(c*4+r) -: 8] = b;
      end
    end
    return t;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      t[BlockW-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[BlockW-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  // inverse mix as a pre-step (04/05 terms) followed by the forward mix
  function automatic block_t mix_inv(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ u;
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ v;
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ u;
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ v;
    end
    return mix_fwd(t);
  endfunction

  function automatic block_t next_key(input block_t k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/aes_round.sv
// One registered cipher round of the unrolled pipeline.
// Depends on aes_pkg.
`default_nettype none
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire aes_pkg::stage_ctl_t ctl_i,
  input  wire aes_pkg::block_t    state_i,
  input  wire aes_pkg::block_t    enc_key_i,
  input  wire aes_pkg::block_t    dec_key_i,
  output aes_pkg::stage_ctl_t     ctl_o,
  output aes_pkg::block_t         state_o
);
  import aes_pkg::*;

  stage_ctl_t ctl_q;
  block_t     state_q, state_d, ss;

  // Decrypt order: inv shift, inv sub, add key, inv mix.
  always_comb begin
    ss = sub_shift(state_i, ctl_i.dec);
    if (ctl_i.dec) begin
      state_d = LastRound ? (ss ^ dec_key_i) : mix_inv(ss ^ dec_key_i);
    end else begin
      state_d = LastRound ? (ss ^ enc_key_i) : (mix_fwd(ss) ^ enc_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_i;
      state_q <= state_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign state_o = state_q;
endmodule
`default_nettype wire

FILE: hdl/aes128_block_cipher.sv
// AES-128 top level: key registers, round key schedule, ten-round pipeline.
// Depends on aes_pkg and aes_round.
//
// Usage: write key_high (index 0) and key_low (index 1) through cfg_we_i while
// no item is in flight; writes to other indexes change no key but still hold
// off input. Round keys are recomputed through a registered chain, so
// in_ready_o stays low after any key write until the chain has settled, and an
// item offered meanwhile just waits. Each item carries op_i (0 encrypt,
// 1 decrypt) and a 128-bit block. From acceptance to result valid an item
// passes one input register for the initial key add, then ten round registers,
// the last of which is the output slot. One item per cycle is accepted while
// in_ready_o is high; the whole pipeline advances together, so in_ready_o is
// low while a result waits with out_ready_i low, and a stall holds every stage
// in place. Reset clears all valid bits and the key registers and holds
// in_ready_o low while the schedule settles to the all-zero key.
`default_nettype none
module aes128_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);
  import aes_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  block_t      rk_q [NumRoundKeys];
  logic        adv;
  logic [3:0]  settle_q, settle_d;
  stage_ctl_t  ctl   [NumRounds+1];
  block_t      st    [NumRounds+1];
  stage_ctl_t  ctl0_q;
  block_t      st0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        8'(CFG_KEY_HIGH): key_high_q <= cfg_data_i;
        8'(CFG_KEY_LOW):  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Key schedule: one registered expansion step per round key after the first.
  always_ff @(posedge clk_i) begin
    rk_q[0] <= {key_high_q, key_low_q};
    for (int r = 1; r < NumRoundKeys; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], 4'(r - 1));
    end
  end

  // input held off until the round key chain has settled
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = 4'(NumRoundKeys);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 4'(NumRoundKeys);
    end else begin
      settle_q <= settle_d;
    end
  end

  // Output slot is the last stage register; the pipeline moves as a whole.
  assign adv        = !ctl[NumRounds].valid || out_ready_i;
  assign in_ready_o = adv && (settle_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (adv) begin
      ctl0_q <= '{valid: in_valid_i && in_ready_o, dec: op_i};
    end
  end

  // Initial whitening with round key 0 or 10.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= {block_high_i, block_low_i} ^ (op_i ? rk_q[NumRounds] : rk_q[0]);
    end
  end

  assign ctl[0] = ctl0_q;
  assign st[0]  = st0_q;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    stage_ctl_t ctl_raw;
    aes_round #(.LastRound(g == NumRounds - 1)) u_round (
      .clk_i     (clk_i),
      .en_i      (adv),
      .ctl_i     (ctl[g]),
      .state_i   (st[g]),
      .enc_key_i (rk_q[g+1]),
      .dec_key_i (rk_q[NumRounds-1-g]),
      .ctl_o     (ctl_raw),
      .state_o   (st[g+1])
    );
    // valid bits need reset; shadow the stage's control with a reset flop
    stage_ctl_t vq;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq <= '0;
      end else if (adv) begin
        vq <= ctl[g];
      end
    end
    assign ctl[g+1] = '{valid: vq.valid, dec: ctl_raw.dec};
  end

  assign out_valid_o   = ctl[NumRounds].valid;
  assign result_high_o = st[NumRounds][127:64];
  assign result_low_o  = st[NumRounds][63:0];
endmodule
`default_nettype wire

FILE: hdl/aes_checker.sv
// Port-level checker for the AES-128 block, bound to the top level.
// Depends on aes128_block_cipher_macros.svh.
`default_nettype none
`include "aes128_block_cipher_macros.svh"
module aes_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_high_o
);
  // a waiting result blocks the input side
  `AES_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken while result waits")
  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_high_o), "result changed while stalled")
  `AES_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i, "input valid dropped while waiting")
endmodule

bind aes128_block_cipher aes_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_high_o (result_high_o)
);
`default_nettype wire
